### rtl/pfvr_pkg.sv
// shared types, widths and constants for the polygon flat vertex removal block
// no dependencies
package pfvr_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS     = 12;
  localparam int THR_W          = 17;
  localparam int Q_SHIFT        = 16;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(57870);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DOT_W  = PROD_W + 1;
  localparam int LEN_W  = PROD_W - 1;
  localparam int DSQ_W  = 2 * DOT_W;
  localparam int LUV_W  = 2 * LEN_W;
  localparam int RHS_W  = LUV_W + THR_W;
  localparam int CMP_W  = DSQ_W + Q_SHIFT;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   point_last;
  } in_item_t;

  typedef struct packed {
    coord_t kept_x;
    coord_t kept_y;
    logic   kept_valid;
    logic   run_end;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic eval;
    logic last;
  } pfvr_cmd_t;

endpackage

### rtl/pfvr_ctrl.sv
// controller: vertex loading, ring read sequencing and walk completion
// depends on pfvr_pkg
module pfvr_ctrl #(
  parameter int MAX_POINTS = pfvr_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            point_last,
  input  logic                            walk_done,
  output logic                            busy,
  output pfvr_pkg::pfvr_cmd_t             cmd,
  output logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
  output logic [$clog2(MAX_POINTS)-1:0]   rd_addr
);
  import pfvr_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int K_W   = $clog2(MAX_POINTS + 2);

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_READ  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [K_W-1:0]   km1;
  logic             accept;
  logic             read_last;

  assign accept    = (state_r == ST_LOAD) && start;
  assign km1       = k_r - K_W'(1);
  assign read_last = (k_r == (K_W'(n_r) + K_W'(1)));
  assign wr_addr   = count_r[AW-1:0];
  assign busy      = (state_r != ST_LOAD);

  always_comb begin
    if (k_r == '0) begin
      rd_addr = AW'(n_r - CNT_W'(1));
    end else if (km1 == K_W'(n_r)) begin
      rd_addr = '0;
    end else begin
      rd_addr = km1[AW-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    cmd.wr_en   = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.eval    = 1'b0;
    cmd.last    = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (count_r < CNT_W'(MAX_POINTS)) begin
            cmd.wr_en = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          if (point_last) begin
            n_nxt     = count_nxt;
            count_nxt = '0;
            k_nxt     = '0;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        cmd.eval  = (k_r >= K_W'(2));
        cmd.last  = read_last;
        k_nxt     = k_r + K_W'(1);
        if (read_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (walk_done) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      n_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

### rtl/pfvr_datapath.sv
// datapath: vertex store, neighbor window, angle test pipeline and result staging
// depends on pfvr_pkg
module pfvr_datapath #(
  parameter int MAX_POINTS = pfvr_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pfvr_pkg::pfvr_cmd_t                 cmd,
  input  logic [$clog2(MAX_POINTS)-1:0]       wr_addr,
  input  logic [$clog2(MAX_POINTS)-1:0]       rd_addr,
  input  pfvr_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [pfvr_pkg::THR_W-1:0]          cfg_data,
  output logic                                walk_done,
  output logic                                out_strobe,
  output pfvr_pkg::out_item_t                 out_data
);
  import pfvr_pkg::*;

  // vertex store
  pt_t store [MAX_POINTS];
  pt_t rd_q_r;

  // threshold register
  logic [THR_W-1:0] thr_r;

  // read and window
  logic rd_v_r, rd_eval_r, rd_last_r;
  pt_t  win_p_r, win_c_r;

  // stage a: edge vectors
  logic                     a_v_r, a_last_r;
  pt_t                      a_c_r;
  logic signed [DIFF_W-1:0] ux_r, uy_r, vx_r, vy_r;

  // stage b: products
  logic                     b_v_r, b_last_r;
  pt_t                      b_c_r;
  logic signed [PROD_W-1:0] pxx_r, pyy_r, uxx_r, uyy_r, vxx_r, vyy_r;

  // stage c: dot and squared lengths
  logic                     c_v_r, c_last_r;
  pt_t                      c_c_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic [LEN_W-1:0]         lu_r, lv_r;

  // stage d: squared dot and length product
  logic                     d_v_r, d_last_r;
  pt_t                      d_c_r;
  logic signed [DSQ_W-1:0]  dsq_r;
  logic [LUV_W-1:0]         luv_r;

  // stage e: both sides of the test
  logic                     e_v_r, e_last_r;
  pt_t                      e_c_r;
  logic [CMP_W-1:0]         lhs_r;
  logic [RHS_W-1:0]         rhs_r;

  // stage f: verdict
  logic                     f_v_r, f_last_r, f_keep_r;
  pt_t                      f_c_r;

  // result staging
  logic      flush_r;
  logic      pend_v_r, pend_v_nxt;
  pt_t       pend_r, pend_nxt;
  logic      out_strobe_r, out_strobe_nxt;
  out_item_t out_data_r, out_data_nxt;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[wr_addr] <= '{x: in_data.point_x, y: in_data.point_y};
    end
    if (cmd.rd_en) begin
      rd_q_r <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  // valid and marker pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r    <= 1'b0;
      rd_eval_r <= 1'b0;
      rd_last_r <= 1'b0;
      a_v_r     <= 1'b0;
      a_last_r  <= 1'b0;
      b_v_r     <= 1'b0;
      b_last_r  <= 1'b0;
      c_v_r     <= 1'b0;
      c_last_r  <= 1'b0;
      d_v_r     <= 1'b0;
      d_last_r  <= 1'b0;
      e_v_r     <= 1'b0;
      e_last_r  <= 1'b0;
      f_v_r     <= 1'b0;
      f_last_r  <= 1'b0;
      flush_r   <= 1'b0;
    end else begin
      rd_v_r    <= cmd.rd_en;
      rd_eval_r <= cmd.rd_en & cmd.eval;
      rd_last_r <= cmd.rd_en & cmd.last;
      a_v_r     <= rd_v_r & rd_eval_r;
      a_last_r  <= rd_v_r & rd_last_r;
      b_v_r     <= a_v_r;
      b_last_r  <= a_last_r;
      c_v_r     <= b_v_r;
      c_last_r  <= b_last_r;
      d_v_r     <= c_v_r;
      d_last_r  <= c_last_r;
      e_v_r     <= d_v_r;
      e_last_r  <= d_last_r;
      f_v_r     <= e_v_r;
      f_last_r  <= e_last_r;
      flush_r   <= f_v_r & f_last_r;
    end
  end

  // arithmetic pipeline
  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      win_p_r <= win_c_r;
      win_c_r <= rd_q_r;
    end
    a_c_r    <= win_c_r;
    ux_r     <= $signed({1'b0, win_p_r.x}) - $signed({1'b0, win_c_r.x});
    uy_r     <= $signed({1'b0, win_p_r.y}) - $signed({1'b0, win_c_r.y});
    vx_r     <= $signed({1'b0, rd_q_r.x}) - $signed({1'b0, win_c_r.x});
    vy_r     <= $signed({1'b0, rd_q_r.y}) - $signed({1'b0, win_c_r.y});

    b_c_r    <= a_c_r;
    pxx_r    <= ux_r * vx_r;
    pyy_r    <= uy_r * vy_r;
    uxx_r    <= ux_r * ux_r;
    uyy_r    <= uy_r * uy_r;
    vxx_r    <= vx_r * vx_r;
    vyy_r    <= vy_r * vy_r;

    c_c_r    <= b_c_r;
    dot_r    <= DOT_W'(pxx_r) + DOT_W'(pyy_r);
    lu_r     <= LEN_W'($unsigned(uxx_r)) + LEN_W'($unsigned(uyy_r));
    lv_r     <= LEN_W'($unsigned(vxx_r)) + LEN_W'($unsigned(vyy_r));

    d_c_r    <= c_c_r;
    dsq_r    <= dot_r * dot_r;
    luv_r    <= lu_r * lv_r;

    e_c_r    <= d_c_r;
    lhs_r    <= {$unsigned(dsq_r), {Q_SHIFT{1'b0}}};
    rhs_r    <= luv_r * thr_r;

    f_c_r    <= e_c_r;
    f_keep_r <= (lhs_r < CMP_W'(rhs_r));
  end

  // kept vertices wait one step so the final one can carry run_end
  always_comb begin
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    if (flush_r) begin
      out_strobe_nxt          = 1'b1;
      out_data_nxt.kept_x     = pend_v_r ? pend_r.x : '0;
      out_data_nxt.kept_y     = pend_v_r ? pend_r.y : '0;
      out_data_nxt.kept_valid = pend_v_r;
      out_data_nxt.run_end    = 1'b1;
      pend_v_nxt              = 1'b0;
    end else if (f_v_r && f_keep_r) begin
      if (pend_v_r) begin
        out_strobe_nxt          = 1'b1;
        out_data_nxt.kept_x     = pend_r.x;
        out_data_nxt.kept_y     = pend_r.y;
        out_data_nxt.kept_valid = 1'b1;
        out_data_nxt.run_end    = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = f_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign walk_done  = flush_r;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

### rtl/polygon_flat_vertex_removal.sv
// top level of the polygon flat vertex removal block
// depends on pfvr_pkg, pfvr_ctrl and pfvr_datapath
//
// Vertices of a closed ring load one per cycle while busy is low; the beat with
// point_last closes the ring. busy then stays high until the walk is done; with
// n the number of stored vertices, the vertex store is read n + 2 times
// to slide a three-vertex window around the ring, and a six-stage
// multiply pipeline decides each vertex. Kept vertices come out on out_strobe
// in input order, one per cycle at most, the last one with run_end set; a ring
// with nothing kept gives one empty beat. Results cannot be held off, so the
// receiver must take every beat. The last beat of a ring shows in the first
// cycle with busy low again. Threshold writes are taken while busy is low.
module polygon_flat_vertex_removal #(
  parameter int MAX_POINTS = pfvr_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  pfvr_pkg::in_item_t           in_data,
  output logic                         out_strobe,
  output pfvr_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pfvr_pkg::THR_W-1:0]   cfg_data
);
  import pfvr_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  pfvr_cmd_t     cmd;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          walk_done;

  assign cfg_ready = ~busy;

  pfvr_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .point_last(in_data.point_last),
    .walk_done (walk_done),
    .busy      (busy),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  pfvr_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .walk_done (walk_done),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  a_end_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.run_end |-> !busy)
    else $error("final beat while still busy");

  a_empty_beat_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.kept_valid |->
      out_data.run_end && out_data.kept_x == '0 && out_data.kept_y == '0)
    else $error("malformed empty beat");

  a_close_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.point_last |=> busy)
    else $error("ring close did not start the walk");

  a_no_beat_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !$past(busy) |-> !out_strobe)
    else $error("result beat outside a walk");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for polygon_flat_vertex_removal: rings of vertices are fed
// through start/busy and every kept vertex is checked against an in-bench predictor
// depends on pfvr_pkg and the polygon_flat_vertex_removal rtl
module tb;
  import pfvr_pkg::*;

  localparam int RING_MAX = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_strobe;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;

  in_item_t vertex_feed_q[$];
  out_item_t kept_vertices_q[$];

  coord_t ring_x[RING_MAX];
  coord_t ring_y[RING_MAX];
  int ring_len = 0;
  logic [THR_W-1:0] cos_sq_limit = THR_RESET;

  int fault_count = 0;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  polygon_flat_vertex_removal dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit vertex_sharp(int c, int p, int q);
    longint ux, uy, vx, vy, d, lu, lv;
    logic [95:0] lhs, rhs;
    ux = longint'(ring_x[p]) - longint'(ring_x[c]);
    uy = longint'(ring_y[p]) - longint'(ring_y[c]);
    vx = longint'(ring_x[q]) - longint'(ring_x[c]);
    vy = longint'(ring_y[q]) - longint'(ring_y[c]);
    d = ux * vx + uy * vy;
    if (d < 0) d = -d;
    lu = ux * ux + uy * uy;
    lv = vx * vx + vy * vy;
    lhs = 96'(d * d) << Q_SHIFT;
    rhs = 96'(lu * lv) * 96'(cos_sq_limit);
    return lhs < rhs;
  endfunction

  task automatic load_vertex(in_item_t it);
    bit keep[RING_MAX];
    int last_kept;
    out_item_t e;
    if (ring_len < RING_MAX) begin
      ring_x[ring_len] = it.point_x;
      ring_y[ring_len] = it.point_y;
      ring_len++;
    end
    if (it.point_last) begin
      last_kept = -1;
      for (int i = 0; i < ring_len; i++) begin
        keep[i] = vertex_sharp(i, (i == 0) ? ring_len - 1 : i - 1,
                               (i + 1 == ring_len) ? 0 : i + 1);
        if (keep[i]) last_kept = i;
      end
      if (last_kept < 0) begin
        e = '{kept_x: '0, kept_y: '0, kept_valid: 1'b0, run_end: 1'b1};
        kept_vertices_q.insert(kept_vertices_q.size(), e);
      end else begin
        for (int i = 0; i < ring_len; i++) begin
          if (keep[i]) begin
            e = '{kept_x: ring_x[i], kept_y: ring_y[i], kept_valid: 1'b1,
                  run_end: (i == last_kept)};
            kept_vertices_q.insert(kept_vertices_q.size(), e);
          end
        end
      end
      ring_len = 0;
    end
  endtask

  // driver: one beat per accepted start
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) load_vertex(in_data);
      if (!start || !busy) begin
        if (vertex_feed_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 35)) begin
          in_data <= vertex_feed_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (kept_vertices_q.size() == 0) begin
        $display("%0t unexpected beat: expected none actual %h", $time, out_data);
        fault_count <= fault_count + 1;
      end else begin
        if (out_data.kept_x !== kept_vertices_q[0].kept_x ||
            out_data.kept_y !== kept_vertices_q[0].kept_y ||
            out_data.kept_valid !== kept_vertices_q[0].kept_valid ||
            out_data.run_end !== kept_vertices_q[0].run_end) begin
          $display("%0t mismatch: expected %0d,%0d v%b e%b actual %0d,%0d v%b e%b",
                   $time, kept_vertices_q[0].kept_x, kept_vertices_q[0].kept_y,
                   kept_vertices_q[0].kept_valid, kept_vertices_q[0].run_end,
                   out_data.kept_x, out_data.kept_y, out_data.kept_valid, out_data.run_end);
          fault_count <= fault_count + 1;
        end
        void'(kept_vertices_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_vertex(int x, int y, bit last);
    in_item_t it;
    it = '{point_x: coord_t'(x), point_y: coord_t'(y), point_last: last};
    vertex_feed_q.insert(vertex_feed_q.size(), it);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (vertex_feed_q.size() != 0 || start || kept_vertices_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cos_sq_limit = v;
  endtask

  task automatic queue_square();
    push_vertex(0, 0, 1'b0);
    push_vertex(4095, 0, 1'b0);
    push_vertex(4095, 4095, 1'b0);
    push_vertex(0, 4095, 1'b1);
  endtask

  // mostly random rings with inserted near-midpoints, some noise, short rings
  task automatic queue_ring();
    int n, kind;
    int bx[16], by[16];
    int mx, my, j;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++)
        push_vertex($urandom_range(0, 4095), $urandom_range(0, 4095), i == n - 1);
    end else if (kind < 30) begin
      n = $urandom_range(3, 6);
      for (int i = 0; i < n; i++)
        push_vertex($urandom_range(0, 4095), $urandom_range(0, 4095), i == n - 1);
    end else begin
      n = $urandom_range(3, 8);
      for (int i = 0; i < n; i++) begin
        bx[i] = $urandom_range(0, 4095);
        by[i] = $urandom_range(0, 4095);
      end
      for (int i = 0; i < n; i++) begin
        j = (i + 1 == n) ? 0 : i + 1;
        if ($urandom_range(0, 99) < 40) begin
          push_vertex(bx[i], by[i], 1'b0);
          mx = (bx[i] + bx[j]) / 2 + $urandom_range(0, 2);
          my = (by[i] + by[j]) / 2 + $urandom_range(0, 2);
          if (mx > 4095) mx = 4095;
          if (my > 4095) my = 4095;
          push_vertex(mx, my, i == n - 1);
        end else begin
          push_vertex(bx[i], by[i], i == n - 1);
        end
      end
    end
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset threshold: square corners, lone vertex, two vertices, straight run, repeat
    queue_square();
    push_vertex(4095, 4095, 1'b1);
    push_vertex(0, 4095, 1'b0);
    push_vertex(4095, 0, 1'b1);
    push_vertex(0, 0, 1'b0);
    push_vertex(100, 0, 1'b0);
    push_vertex(200, 0, 1'b0);
    push_vertex(200, 200, 1'b1);
    push_vertex(5, 5, 1'b0);
    push_vertex(5, 5, 1'b0);
    push_vertex(300, 10, 1'b0);
    push_vertex(10, 300, 1'b1);
    wait_drained();

    // zero threshold keeps nothing
    write_threshold('0);
    queue_square();
    wait_drained();

    // threshold above one keeps even straight vertices
    write_threshold({THR_W{1'b1}});
    push_vertex(0, 0, 1'b0);
    push_vertex(2, 0, 1'b0);
    push_vertex(4, 0, 1'b1);
    wait_drained();

    write_threshold(THR_W'(65536));
    push_vertex(1, 2, 1'b0);
    push_vertex(4095, 7, 1'b0);
    push_vertex(2000, 4000, 1'b1);
    wait_drained();

    // random phases, the first one starts with an overfull ring
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_threshold(THR_RESET);
        1: write_threshold(THR_W'($urandom_range(0, 131071)));
        2: write_threshold(THR_W'($urandom_range(60000, 65536)));
        default: write_threshold(THR_W'($urandom_range(1, 131071)));
      endcase
      no_gaps = (ph == 2);
      if (ph == 0) begin
        n = $urandom_range(65, 68);
        for (int i = 0; i < n; i++)
          push_vertex($urandom_range(0, 4095), $urandom_range(0, 4095), i == n - 1);
      end
      while (vertex_feed_q.size() < 10) queue_ring();
      wait_drained();
    end
    no_gaps = 1'b0;

    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
